### rtl/thermistor_temperature_averager_core_macros.svh
// Assertion macros for the thermistor temperature averager.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef THERMISTOR_TEMPERATURE_AVERAGER_CORE_MACROS_SVH
`define THERMISTOR_TEMPERATURE_AVERAGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define AST_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_ALWAYS(lbl, clk, rst, prop)
`define AST_NOW(lbl, clk, rst, ante, cons)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/tta_pkg.sv
// Shared types and constants for the thermistor temperature averager.
// Used by the controller, datapath and top level.
package tta_pkg;

  localparam logic [9:0]         ADC_FULL      = 10'd1023;
  localparam logic [31:0]        LN2_Q32       = 32'hB172_17F8;
  localparam logic [63:0]        HUNDRED_Q48   = 64'h0064_0000_0000_0000;
  localparam logic [16:0]        TEMP_SAT_Q    = 17'd127315;
  localparam logic signed [17:0] TEMP_MAX      = 18'sd100000;
  localparam logic signed [17:0] KELVIN_OFFSET = 18'sd27315;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_NORM_INIT,
    OP_NORM_STEP,
    OP_MUL_STEP,
    OP_SQ_UPDATE,
    OP_LN_DONE,
    OP_X2,
    OP_X3,
    OP_TERM_B,
    OP_TERM_C,
    OP_DIV2_INIT,
    OP_TEMP,
    OP_HIST,
    OP_AVG_INIT,
    OP_AVG,
    OP_REJECT
  } op_t;

  typedef enum logic [2:0] {
    SRC_MM,
    SRC_LN,
    SRC_XX,
    SRC_X2X,
    SRC_BX,
    SRC_CX3
  } src_t;

  typedef struct packed {
    op_t        op;
    src_t       src;
    logic [1:0] idx;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic norm_done;
    logic dpos;
  } sts_t;

endpackage

### rtl/tta_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module tta_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tta_regs.sv
// APB-style configuration registers: series resistor and Steinhart-Hart coefficients.
// Depends on nothing but the clock and reset.
module tta_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output logic [15:0]        series_resistance,
  output logic signed [47:0] coef_a,
  output logic signed [47:0] coef_b,
  output logic signed [47:0] coef_c
);

  localparam logic [1:0] REG_RS = 2'd0;
  localparam logic [1:0] REG_A  = 2'd1;
  localparam logic [1:0] REG_B  = 2'd2;
  localparam logic [1:0] REG_C  = 2'd3;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance <= 16'd10000;
      coef_a            <= 48'sd284078486000;
      coef_b            <= 48'sd66946000000;
      coef_c            <= 48'sd56835500;
    end else if (wr) begin
      case (paddr[4:3])
        REG_RS:  series_resistance <= pwdata[15:0];
        REG_A:   coef_a            <= pwdata[47:0];
        REG_B:   coef_b            <= pwdata[47:0];
        REG_C:   coef_c            <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_RS:  prdata = {48'd0, series_resistance};
      REG_A:   prdata = {16'd0, coef_a};
      REG_B:   prdata = {16'd0, coef_b};
      REG_C:   prdata = {16'd0, coef_c};
      default: prdata = 64'd0;
    endcase
  end

endmodule

### rtl/tta_dp.sv
// Datapath: shared restoring divider, 32x32 multiplier with accumulator, log2 squaring,
// Steinhart-Hart sum, history RAM and output registers. Uses tta_pkg and tta_ram.
`include "thermistor_temperature_averager_core_macros.svh"
module tta_dp
  import tta_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [9:0]         adc_sample,
  input  logic [15:0]        series_resistance,
  input  logic signed [47:0] coef_a,
  input  logic signed [47:0] coef_b,
  input  logic signed [47:0] coef_c,
  output logic               sample_valid,
  output logic signed [17:0] temp_now,
  output logic signed [17:0] temp_average
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = 18 + $clog2(HISTORY_DEPTH);
  // ceil(2^32 / depth): exact floor division of the history sum magnitude
  localparam logic [63:0] AVG_RECIP_W =
    ((64'd1 << 32) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [32:0] AVG_RECIP = AVG_RECIP_W[32:0];

  logic [9:0]                smp;
  logic [63:0]               quo;
  logic [63:0]               rem;
  logic [63:0]               dvs;
  logic [31:0]               m;
  logic [4:0]                k;
  logic [23:0]               frac;
  logic [28:0]               x;
  logic [39:0]               x2;
  logic [39:0]               x3;
  logic [95:0]               acc;
  logic signed [63:0]        d;
  logic                      dpos;
  logic signed [17:0]        cur_temp;
  logic signed [17:0]        avg;
  logic signed [SUM_W-1:0]   sum;
  logic [PTR_W-1:0]          slot;
  logic [HISTORY_DEPTH-1:0]  vld;

  logic [25:0]               prod;
  logic [25:0]               r_adj;
  logic [47:0]               mul_u;
  logic [47:0]               mul_v;
  logic [31:0]               ha;
  logic [31:0]               hb;
  logic [63:0]               pp;
  logic [95:0]               pp_sh;
  logic [47:0]               b_mag;
  logic [47:0]               c_mag;
  logic [63:0]               rem2;
  logic                      ge;
  logic [31:0]               m2;
  logic [63:0]               lsum;
  logic signed [63:0]        term;
  logic                      q_sat;
  logic signed [17:0]        t_calc;
  logic [17:0]               rdata;
  logic signed [17:0]        old;
  logic [SUM_W-1:0]          smag;
  logic [SUM_W-1:0]          avg_num;
  logic [SUM_W+32:0]         avg_prod;
  logic signed [17:0]        avg_new;

  assign prod  = adc_sample * series_resistance;
  assign r_adj = (quo[25:0] == 26'd0) ? 26'd1 : quo[25:0];
  assign b_mag = coef_b[47] ? (~coef_b + 48'd1) : coef_b;
  assign c_mag = coef_c[47] ? (~coef_c + 48'd1) : coef_c;

  always_comb begin
    case (cmd.src)
      SRC_MM:  begin mul_u = {16'd0, m};            mul_v = {16'd0, m};       end
      SRC_LN:  begin mul_u = {19'd0, k, frac};      mul_v = {16'd0, LN2_Q32}; end
      SRC_XX:  begin mul_u = {19'd0, x};            mul_v = {19'd0, x};       end
      SRC_X2X: begin mul_u = {8'd0, x2};            mul_v = {19'd0, x};       end
      SRC_BX:  begin mul_u = b_mag;                 mul_v = {19'd0, x};       end
      SRC_CX3: begin mul_u = c_mag;                 mul_v = {8'd0, x3};       end
      default: begin mul_u = 48'd0;                 mul_v = 48'd0;            end
    endcase
  end

  assign ha = cmd.idx[1] ? {16'd0, mul_u[47:32]} : mul_u[31:0];
  assign hb = cmd.idx[0] ? {16'd0, mul_v[47:32]} : mul_v[31:0];
  assign pp = ha * hb;

  always_comb begin
    case (cmd.idx)
      2'd0:    pp_sh = {32'd0, pp};
      2'd3:    pp_sh = {pp[31:0], 64'd0};
      default: pp_sh = {pp, 32'd0};
    endcase
  end

  assign rem2 = {rem[62:0], quo[63]};
  assign ge   = (rem2 >= dvs);
  assign m2   = acc[61:30];
  assign lsum = acc[63:0] + 64'h0000_0000_8000_0000;

  always_comb begin
    if (cmd.op == OP_TERM_B) begin
      term = coef_b[47] ? -$signed({2'b00, acc[85:24]}) : $signed({2'b00, acc[85:24]});
    end else begin
      term = coef_c[47] ? -$signed({2'b00, acc[85:24]}) : $signed({2'b00, acc[85:24]});
    end
  end

  assign q_sat  = (quo[63:17] != 47'd0) || (quo[16:0] > TEMP_SAT_Q);
  assign t_calc = (!dpos || q_sat) ? TEMP_MAX : ($signed({1'b0, quo[16:0]}) - KELVIN_OFFSET);
  assign old    = vld[slot] ? $signed(rdata) : 18'sd0;
  assign smag   = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  // negative sums round the magnitude up so the mean is a floor
  assign avg_num  = smag + (sum[SUM_W-1] ? SUM_W'(HISTORY_DEPTH - 1) : SUM_W'(0));
  assign avg_prod = {33'd0, avg_num} * {{SUM_W{1'b0}}, AVG_RECIP};
  assign avg_new = sum[SUM_W-1] ? -$signed(quo[17:0]) : $signed(quo[17:0]);

  tta_ram #(
    .WIDTH(18),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.op == OP_HIST),
    .waddr(slot),
    .wdata(cur_temp),
    .re   (cmd.op == OP_TEMP),
    .raddr(slot),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_temp <= 18'sd0;
      avg       <= 18'sd0;
      sum       <= '0;
      slot      <= '0;
      vld       <= '0;
      dpos      <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          smp <= adc_sample;
          quo <= 64'(prod);
          dvs <= 64'(ADC_FULL - adc_sample);
          rem <= 64'd0;
        end
        OP_DIV_STEP: begin
          rem <= ge ? (rem2 - dvs) : rem2;
          quo <= {quo[62:0], ge};
        end
        OP_NORM_INIT: begin
          m    <= {1'b0, r_adj, 5'd0};
          k    <= 5'd25;
          frac <= 24'd0;
        end
        OP_NORM_STEP: begin
          m <= {m[30:0], 1'b0};
          k <= k - 5'd1;
        end
        OP_MUL_STEP: acc <= cmd.first ? pp_sh : (acc + pp_sh);
        OP_SQ_UPDATE: begin
          frac <= {frac[22:0], m2[31]};
          m    <= m2[31] ? {1'b0, m2[31:1]} : m2;
        end
        OP_LN_DONE: x  <= lsum[60:32];
        OP_X2:      x2 <= acc[63:24];
        OP_X3:      x3 <= acc[63:24];
        OP_TERM_B:  d  <= 64'(coef_a) + term;
        OP_TERM_C:  d  <= d + term;
        OP_DIV2_INIT: begin
          dpos <= !d[63] && (d != 64'sd0);
          quo  <= HUNDRED_Q48 + {1'b0, d[63:1]};
          dvs  <= d;
          rem  <= 64'd0;
        end
        OP_TEMP: cur_temp <= t_calc;
        OP_HIST: begin
          sum       <= sum - SUM_W'(old) + SUM_W'(cur_temp);
          vld[slot] <= 1'b1;
          slot      <= (slot == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : slot + PTR_W'(1);
        end
        OP_AVG_INIT: begin
          quo <= 64'(avg_prod[SUM_W+32:32]);
        end
        OP_AVG: begin
          avg          <= avg_new;
          sample_valid <= 1'b1;
          temp_now     <= cur_temp;
          temp_average <= avg_new;
        end
        OP_REJECT: begin
          sample_valid <= 1'b0;
          temp_now     <= cur_temp;
          temp_average <= avg;
        end
        default: ;
      endcase
    end
  end

  assign sts.reject    = (smp == 10'd0) || (smp == ADC_FULL);
  assign sts.norm_done = m[30];
  assign sts.dpos      = dpos;

  `AST_ALWAYS(a_slot_range, clk, rst, 32'(slot) < HISTORY_DEPTH)
  `AST_NEXT(a_temp_sat, clk, rst, (cmd.op == OP_TEMP) && !dpos, cur_temp == TEMP_MAX)
  `AST_NEXT(a_hist_valid, clk, rst, cmd.op == OP_HIST, vld != '0)

endmodule

### rtl/tta_ctrl.sv
// Sequencer for the temperature datapath: issues one command per cycle.
// Uses tta_pkg types; drives the stream handshakes.
`include "thermistor_temperature_averager_core_macros.svh"
module tta_ctrl
  import tta_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_REJECT,
    S_DIV_R,
    S_NORM_INIT,
    S_NORM,
    S_SQ_MUL,
    S_SQ_UPD,
    S_LN_MUL,
    S_LN_DONE,
    S_X2_MUL,
    S_X2_DONE,
    S_X3_MUL,
    S_X3_DONE,
    S_B_MUL,
    S_B_DONE,
    S_C_MUL,
    S_C_DONE,
    S_DIV2_INIT,
    S_DIV_T,
    S_TEMP,
    S_HIST,
    S_AVG_INIT,
    S_FINISH
  } state_t;

  state_t     state;
  logic [5:0] cnt;
  logic [4:0] sq;
  logic       out_free;
  logic       issue_out;

  assign out_free  = !m_tvalid || m_tready;
  assign issue_out = ((state == S_REJECT) || (state == S_FINISH)) && out_free;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.src   = SRC_MM;
    cmd.idx   = cnt[1:0];
    cmd.first = (cnt[1:0] == 2'd0);
    case (state)
      S_IDLE:      if (s_tvalid) cmd.op = OP_LOAD;
      S_REJECT:    if (out_free) cmd.op = OP_REJECT;
      S_DIV_R:     cmd.op = OP_DIV_STEP;
      S_NORM_INIT: cmd.op = OP_NORM_INIT;
      S_NORM:      if (!sts.norm_done) cmd.op = OP_NORM_STEP;
      S_SQ_MUL: begin
        cmd.op    = OP_MUL_STEP;
        cmd.idx   = 2'd0;
        cmd.first = 1'b1;
      end
      S_SQ_UPD:    cmd.op = OP_SQ_UPDATE;
      S_LN_MUL: begin
        cmd.op    = OP_MUL_STEP;
        cmd.src   = SRC_LN;
        cmd.idx   = 2'd0;
        cmd.first = 1'b1;
      end
      S_LN_DONE:   cmd.op = OP_LN_DONE;
      S_X2_MUL:    begin cmd.op = OP_MUL_STEP; cmd.src = SRC_XX;  end
      S_X2_DONE:   cmd.op = OP_X2;
      S_X3_MUL:    begin cmd.op = OP_MUL_STEP; cmd.src = SRC_X2X; end
      S_X3_DONE:   cmd.op = OP_X3;
      S_B_MUL:     begin cmd.op = OP_MUL_STEP; cmd.src = SRC_BX;  end
      S_B_DONE:    cmd.op = OP_TERM_B;
      S_C_MUL:     begin cmd.op = OP_MUL_STEP; cmd.src = SRC_CX3; end
      S_C_DONE:    cmd.op = OP_TERM_C;
      S_DIV2_INIT: cmd.op = OP_DIV2_INIT;
      S_DIV_T:     if (sts.dpos) cmd.op = OP_DIV_STEP;
      S_TEMP:      cmd.op = OP_TEMP;
      S_HIST:      cmd.op = OP_HIST;
      S_AVG_INIT:  cmd.op = OP_AVG_INIT;
      S_FINISH:    if (out_free) cmd.op = OP_AVG;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 6'd0;
      sq       <= 5'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (issue_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE:      if (s_tvalid) state <= S_CHECK;
        S_CHECK: begin
          cnt   <= 6'd0;
          state <= sts.reject ? S_REJECT : S_DIV_R;
        end
        S_REJECT:    if (out_free) state <= S_IDLE;
        S_DIV_R: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_NORM_INIT;
        end
        S_NORM_INIT: state <= S_NORM;
        S_NORM: begin
          sq <= 5'd0;
          if (sts.norm_done) state <= S_SQ_MUL;
        end
        S_SQ_MUL:    state <= S_SQ_UPD;
        S_SQ_UPD: begin
          sq    <= sq + 5'd1;
          state <= (sq == 5'd23) ? S_LN_MUL : S_SQ_MUL;
        end
        S_LN_MUL:    state <= S_LN_DONE;
        S_LN_DONE: begin
          cnt   <= 6'd0;
          state <= S_X2_MUL;
        end
        S_X2_MUL, S_X3_MUL, S_B_MUL, S_C_MUL: begin
          if (cnt[1:0] == 2'd3) begin
            cnt <= 6'd0;
            case (state)
              S_X2_MUL: state <= S_X2_DONE;
              S_X3_MUL: state <= S_X3_DONE;
              S_B_MUL:  state <= S_B_DONE;
              default:  state <= S_C_DONE;
            endcase
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_X2_DONE:   state <= S_X3_MUL;
        S_X3_DONE:   state <= S_B_MUL;
        S_B_DONE:    state <= S_C_MUL;
        S_C_DONE:    state <= S_DIV2_INIT;
        S_DIV2_INIT: begin
          cnt   <= 6'd0;
          state <= S_DIV_T;
        end
        S_DIV_T: begin
          if (!sts.dpos) begin
            cnt   <= 6'd0;
            state <= S_TEMP;
          end else begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'd63) state <= S_TEMP;
          end
        end
        S_TEMP:      state <= S_HIST;
        S_HIST:      state <= S_AVG_INIT;
        S_AVG_INIT: begin
          cnt   <= 6'd0;
          state <= S_FINISH;
        end
        S_FINISH:    if (out_free) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

  `AST_NEXT(a_accept_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  `AST_NOW(a_out_free, clk, rst, (cmd.op == OP_AVG) || (cmd.op == OP_REJECT), out_free)
  `AST_NOW(a_load_idle, clk, rst, cmd.op == OP_LOAD, s_tready && s_tvalid)

endmodule

### rtl/thermistor_temperature_averager_core.sv
// Thermistor thermometer with moving average: one ADC sample in, one result beat out. A
// sample of 0 or full scale passes the check state to the reject state, which raises the
// result with sample_valid low and the stored temperature and mean. Any other sample runs
// two 64-step passes of the shared restoring divider (resistance, reciprocal temperature),
// a normalize pass and 24 squarings for the logarithm, products through the one 32x32
// multiplier and the load, check and update states; the mean is one reciprocal multiply. A
// denominator that is not positive skips the second division. A result waiting on m_tready
// holds the next sample in its last cycle. One sample is in work at a time; the next is
// taken while the previous result waits in the output register.
// Depends on tta_pkg, tta_regs, tta_dp, tta_ctrl.
module thermistor_temperature_averager_core
  import tta_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] adc_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [17:0] temp_now, [35:18] temp_average
  output logic [0:0]  m_tuser,   // [0] sample_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [15:0]        series_resistance;
  logic signed [47:0] coef_a;
  logic signed [47:0] coef_b;
  logic signed [47:0] coef_c;
  cmd_t               cmd;
  sts_t               sts;
  logic               sample_valid;
  logic signed [17:0] temp_now;
  logic signed [17:0] temp_average;

  tta_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .series_resistance(series_resistance),
    .coef_a           (coef_a),
    .coef_b           (coef_b),
    .coef_c           (coef_c)
  );

  tta_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  tta_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .adc_sample       (s_tdata[9:0]),
    .series_resistance(series_resistance),
    .coef_a           (coef_a),
    .coef_b           (coef_b),
    .coef_c           (coef_c),
    .sample_valid     (sample_valid),
    .temp_now         (temp_now),
    .temp_average     (temp_average)
  );

  assign m_tdata = {4'd0, temp_average, temp_now};
  assign m_tuser = sample_valid;

endmodule
